/* sv/path_wall_segment_intersect_assert.svh */
// Assertion macros shared by pwsi_cell and the top module.
`ifndef PATH_WALL_SEGMENT_INTERSECT_ASSERT_SVH
`define PATH_WALL_SEGMENT_INTERSECT_ASSERT_SVH
`ifndef SYNTH
// Check while out of reset.
`define PWSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check at every edge, reset included.
`define PWSI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWSI_ASSERT(label, prop, msg)
`define PWSI_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* sv/pwsi_pkg.sv */
package pwsi_pkg;

  localparam int CoordW = 32;
  localparam int QuotW  = 17;
  localparam int DivCells = 16;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CoordW-1:0] rem;
    logic [CoordW-1:0] den;
    logic [QuotW-1:0]  q;
    logic [CoordW-1:0] px0;
    logic [CoordW-1:0] pz0;
    logic [CoordW-1:0] pdx;
    logic [CoordW-1:0] pdz;
  } div_t;

  // Signed 16.16 product, floor shift by 16, wrapped to 32 bits.
  function automatic logic [CoordW-1:0] mul16(input logic signed [CoordW-1:0] a,
                                              input logic signed [CoordW-1:0] b);
    logic signed [2*CoordW-1:0] p;
    p = a * b;
    return p[CoordW+15:16];
  endfunction

endpackage

/* sv/pwsi_cell.sv */
`include "path_wall_segment_intersect_assert.svh"

module pwsi_cell import pwsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  div_t  din,
  output div_t  dout
);

  logic [CoordW:0] r2;
  logic            ge;
  logic [CoordW:0] rsub;

  always_comb begin
    r2   = {din.rem, 1'b0};
    ge   = r2 >= {1'b0, din.den};
    rsub = ge ? (r2 - {1'b0, din.den}) : r2;
  end

  // Shift, compare and subtract one quotient bit per cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.hit <= din.hit;
      dout.rem <= rsub[CoordW-1:0];
      dout.den <= din.den;
      dout.q   <= {din.q[QuotW-2:0], ge};
      dout.px0 <= din.px0;
      dout.pz0 <= din.pz0;
      dout.pdx <= din.pdx;
      dout.pdz <= din.pdz;
    end
  end

  `PWSI_ASSERT(a_rem_below_den, dout.valid |-> (dout.rem < dout.den), "remainder not below divisor")
  `PWSI_ASSERT(a_den_nonzero, dout.valid |-> (dout.den != '0), "zero divisor in chain")
  `PWSI_ASSERT_ALWAYS(a_rst_clears, rst |=> !dout.valid, "valid survives reset")

endmodule

/* sv/pwsi_front.sv */
module pwsi_front import pwsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [8*CoordW-1:0] in_data,
  output div_t              dout
);

  logic signed [CoordW-1:0] px0, pz0, px1, pz1, wx0, wz0, wx1, wz1;
  logic signed [CoordW-1:0] pdx_c, pdz_c, wdx_c, wdz_c, xlo, xhi, zlo, zhi;
  logic                     miss_xz;

  // Stage A registers
  logic                     va, oka;
  logic signed [CoordW-1:0] pdx_a, pdz_a, wdx_a, wdz_a, ox_a, oz_a, px0_a, pz0_a;
  // Stage B registers
  logic                     vb, okb;
  logic signed [CoordW-1:0] m1, m2, m3, m4, m5, m6, px0_b, pz0_b, pdx_b, pdz_b;
  // Stage C registers
  logic                     vc, okc;
  logic signed [CoordW-1:0] num, den, num2, px0_c, pz0_c, pdx_c2, pdz_c2;

  logic                     miss_cp, hit_d;
  logic [CoordW-1:0]        nmag, dmag;

  always_comb begin
    px0 = in_data[0*CoordW +: CoordW];
    pz0 = in_data[1*CoordW +: CoordW];
    px1 = in_data[2*CoordW +: CoordW];
    pz1 = in_data[3*CoordW +: CoordW];
    wx0 = in_data[4*CoordW +: CoordW];
    wz0 = in_data[5*CoordW +: CoordW];
    wx1 = in_data[6*CoordW +: CoordW];
    wz1 = in_data[7*CoordW +: CoordW];
    pdx_c = px1 - px0;
    pdz_c = pz1 - pz0;
    wdx_c = wx0 - wx1;
    wdz_c = wz0 - wz1;
    xlo = (pdx_c < 0) ? px1 : px0;
    xhi = (pdx_c < 0) ? px0 : px1;
    zlo = (pdz_c < 0) ? pz1 : pz0;
    zhi = (pdz_c < 0) ? pz0 : pz1;
    miss_xz = 1'b0;
    if (wdx_c > 0) begin
      if (xhi < wx1 || wx0 < xlo) miss_xz = 1'b1;
    end else begin
      if (xhi < wx0 || wx1 < xlo) miss_xz = 1'b1;
    end
    if (wdz_c > 0 && zhi < wz1) miss_xz = 1'b1;
    if (wz0 < zlo && (zhi < wz0 || wz1 < zlo)) miss_xz = 1'b1;
  end

  always_comb begin
    miss_cp = 1'b0;
    if (den <= 0) begin
      if (num > 0 || num < den) miss_cp = 1'b1;
    end else begin
      if (den > num) miss_cp = 1'b1;
    end
    if (den > 0 && num2 > den) miss_cp = 1'b1;
    if (num2 > 0 || num2 < den) miss_cp = 1'b1;
    if (den == 0) miss_cp = 1'b1;
    hit_d = okc && !miss_cp;
    // A hit leaves den < 0 and den <= num <= 0: divide magnitudes.
    nmag = -num;
    dmag = -den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      dout.valid <= vc;
    end
    if (en) begin
      oka   <= !miss_xz;
      pdx_a <= pdx_c;
      pdz_a <= pdz_c;
      wdx_a <= wdx_c;
      wdz_a <= wdz_c;
      ox_a  <= px0 - wx0;
      oz_a  <= pz0 - wz0;
      px0_a <= px0;
      pz0_a <= pz0;

      okb   <= oka;
      m1    <= mul16(wdz_a, ox_a);
      m2    <= mul16(wdx_a, oz_a);
      m3    <= mul16(pdz_a, wdx_a);
      m4    <= mul16(pdx_a, wdz_a);
      m5    <= mul16(pdx_a, oz_a);
      m6    <= mul16(pdz_a, ox_a);
      px0_b <= px0_a;
      pz0_b <= pz0_a;
      pdx_b <= pdx_a;
      pdz_b <= pdz_a;

      okc    <= okb;
      num    <= m1 - m2;
      den    <= m3 - m4;
      num2   <= m5 - m6;
      px0_c  <= px0_b;
      pz0_c  <= pz0_b;
      pdx_c2 <= pdx_b;
      pdz_c2 <= pdz_b;

      // Leading quotient bit; a miss runs the chain on 0 / 1.
      dout.hit <= hit_d;
      dout.den <= hit_d ? dmag : CoordW'(1);
      dout.q   <= {16'd0, hit_d && (nmag == dmag)};
      dout.rem <= (!hit_d) ? '0 : ((nmag == dmag) ? '0 : nmag);
      dout.px0 <= px0_c;
      dout.pz0 <= pz0_c;
      dout.pdx <= pdx_c2;
      dout.pdz <= pdz_c2;
    end
  end

endmodule

/* sv/path_wall_segment_intersect.sv */
// Channel | Dir | Signals                         | Word
// s       | in  | s_tvalid s_tready s_tdata[255:0] | one path/wall pair
// m       | out | m_tvalid m_tready m_tdata[63:0]  | hit point, hit flag on m_tuser
//
// One pair enters per cycle unless the output stalls; each result passes through
// 4 front stages, 16 divide cells, 1 multiply stage and 1 output register.
// The quotient t = (num << 16) / den is formed one bit per cell in the chain.
// rst synchronously clears every valid bit; payload registers keep no reset.
// The whole pipe holds when a result waits and m_tready is low; s_tready
// then drops in the same cycle.
`include "path_wall_segment_intersect_assert.svh"

module path_wall_segment_intersect import pwsi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // path_start_x, path_start_z, path_end_x, path_end_z,
  // wall_start_x, wall_start_z, wall_end_x, wall_end_z
  input  logic [255:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // hit_x, hit_z
  output logic [63:0]   m_tdata,
  // hit
  output logic          m_tuser
);

  logic en;
  div_t chain [0:DivCells];

  // Advance everything unless the output word is stalled.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  pwsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .dout     (chain[0])
  );

  for (genvar i = 0; i < DivCells; i++) begin : g_cell
    pwsi_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Multiply stage: mul16(t, delta) per axis.
  logic                     vm, hm;
  logic [CoordW-1:0]        mx, mz, px0_m, pz0_m;
  logic signed [CoordW-1:0] tq;

  assign tq = $signed({{(CoordW-QuotW){1'b0}}, chain[DivCells].q});

  always_ff @(posedge clk) begin
    if (rst) begin
      vm       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vm       <= chain[DivCells].valid;
      m_tvalid <= vm;
    end
    if (en) begin
      hm    <= chain[DivCells].hit;
      mx    <= mul16(tq, chain[DivCells].pdx);
      mz    <= mul16(tq, chain[DivCells].pdz);
      px0_m <= chain[DivCells].px0;
      pz0_m <= chain[DivCells].pz0;
      // Zero the point on a miss.
      m_tuser <= hm;
      m_tdata <= hm ? {pz0_m + mz, px0_m + mx} : '0;
    end
  end

  `PWSI_ASSERT(a_stall_blocks, (m_tvalid && !m_tready) |-> !s_tready, "input taken during stall")
  `PWSI_ASSERT(a_miss_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "miss with nonzero point")
  `PWSI_ASSERT_ALWAYS(a_rst_empty, rst |=> (!m_tvalid && !vm), "valid survives reset")

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_PAIRS = 1400;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // path_start_x, path_start_z, path_end_x, path_end_z,
  // wall_start_x, wall_start_z, wall_end_x, wall_end_z
  logic [255:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // hit_x, hit_z
  logic [63:0]  m_tdata;
  // hit
  logic         m_tuser;

  // One path/wall pair as it travels on s_tdata.
  typedef struct packed {
    logic signed [31:0] wz1;
    logic signed [31:0] wx1;
    logic signed [31:0] wz0;
    logic signed [31:0] wx0;
    logic signed [31:0] pz1;
    logic signed [31:0] px1;
    logic signed [31:0] pz0;
    logic signed [31:0] px0;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_x;
    logic [31:0] hit_z;
  } crossing_t;

  // Directed row: the pair, plus a typed-in answer where it is obvious.
  typedef struct {
    pair_t     pair;
    bit        known;
    crossing_t answer;
  } row_t;

  crossing_t   crossing_q[$];
  int unsigned fail_count;
  int unsigned word_count;
  int unsigned hit_count;
  int unsigned idle_cycles;
  bit          quiet_sink;
  bit          hold_sink;

  path_wall_segment_intersect uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor-shifted 16.16 product, wrapped to 32 bits.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b);
      return p[47:16];
    end
  endfunction

  // Compute the crossing of one path with one wall, ordered rejections first.
  function automatic crossing_t cross_path(input pair_t p);
    logic signed [31:0] pdx, pdz, wdx, wdz, lo, hi, ox, oz, num, den, num2, t;
    logic signed [63:0] quot;
    crossing_t r;
    begin
      r = '0;
      pdx = p.px1 - p.px0;
      wdx = p.wx0 - p.wx1;
      lo = (pdx < 0) ? p.px1 : p.px0;
      hi = (pdx < 0) ? p.px0 : p.px1;
      if (wdx > 0) begin
        if (hi < p.wx1 || p.wx0 < lo) return r;
      end else begin
        if (hi < p.wx0 || p.wx1 < lo) return r;
      end
      pdz = p.pz1 - p.pz0;
      wdz = p.wz0 - p.wz1;
      lo = (pdz < 0) ? p.pz1 : p.pz0;
      hi = (pdz < 0) ? p.pz0 : p.pz1;
      if (wdz > 0 && hi < p.wz1) return r;
      if (p.wz0 < lo && (hi < p.wz0 || p.wz1 < lo)) return r;
      ox = p.px0 - p.wx0;
      oz = p.pz0 - p.wz0;
      num = fx_mul(wdz, ox) - fx_mul(wdx, oz);
      den = fx_mul(pdz, wdx) - fx_mul(pdx, wdz);
      if (den <= 0) begin
        if (num > 0 || num < den) return r;
      end else if (den > num) begin
        return r;
      end
      num2 = fx_mul(pdx, oz) - fx_mul(pdz, ox);
      if (den > 0 && num2 > den) return r;
      if (num2 > 0 || num2 < den) return r;
      if (den == 0) return r;
      // SV signed division truncates toward zero, as wanted.
      quot = (64'(num) * 64'sd65536) / 64'(den);
      t = quot[31:0];
      r.hit = 1'b1;
      r.hit_x = p.px0 + fx_mul(t, pdx);
      r.hit_z = p.pz0 + fx_mul(t, pdz);
      return r;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    begin
      $display("MISMATCH word %0d %s: got %h, want %h", word_count, what, got, want);
      fail_count++;
    end
  endtask

  // Random coordinate: near a small box, or anywhere when wide is set.
  function automatic logic signed [31:0] rand_coord(input bit wide);
    begin
      if (wide) return $urandom;
      return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    end
  endfunction

  // Random pair; most put a wall across the path through its midpoint.
  function automatic pair_t rand_pair();
    pair_t p;
    logic signed [31:0] mx, mz;
    int unsigned mode;
    begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        p.px0 = rand_coord(0);
        p.pz0 = rand_coord(0);
        p.px1 = rand_coord(0);
        p.pz1 = rand_coord(0);
        mx = (p.px0 >>> 1) + (p.px1 >>> 1);
        mz = (p.pz0 >>> 1) + (p.pz1 >>> 1);
        p.wx0 = mx + ($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        p.wz0 = mz + ($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        p.wx1 = 2 * mx - p.wx0;
        p.wz1 = 2 * mz - p.wz0;
      end else if (mode < 8) begin
        p = {rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
             rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0)};
      end else begin
        p = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      end
      return p;
    end
  endfunction

  task automatic send_pair(input pair_t p);
    begin
      while (!quiet_sink && $urandom_range(0, 99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= p;
      // Record the expectation once the word is really taken.
      do @(posedge clk); while (!s_tready);
      crossing_q.push_back(cross_path(p));
    end
  endtask

  // Drive the result side: random stalls, a quiet stretch, one long hold.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_sink ? 1'b1 : ($urandom_range(0, 99) >= 12);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (crossing_q.size() == 0) begin
        report_mismatch("word with no pair outstanding", m_tdata[31:0], 32'(0));
      end else begin
        want = crossing_q.pop_front();
        if (m_tuser !== want.hit) report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
        if (m_tdata[31:0] !== want.hit_x) report_mismatch("hit_x", m_tdata[31:0], want.hit_x);
        if (m_tdata[63:32] !== want.hit_z) report_mismatch("hit_z", m_tdata[63:32], want.hit_z);
        hit_count += want.hit;
      end
      word_count++;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the receiver off for a long stretch once, mid-run.
  initial begin
    int unsigned n;
    hold_sink = 1'b0;
    wait (word_count > 300);
    @(posedge clk);
    hold_sink = 1'b1;
    for (n = 0; n < 120; n++) @(posedge clk);
    hold_sink = 1'b0;
  end

  initial begin
    row_t        rows[$];
    row_t        r;
    pair_t       p;
    crossing_t   c;
    int unsigned i, drain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet_sink = 1'b0;
    fail_count = 0;
    word_count = 0;
    hit_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table; rows with known=1 carry a hand-read answer.
    // All zero: degenerate, den is zero -> miss.
    r.pair = '0; r.known = 1; r.answer = '0; rows.push_back(r);
    // X extents disjoint -> miss.
    r.pair = {32'sh0001_0000, 32'sh0050_0000, -32'sh0001_0000, 32'sh0050_0000,
              32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0000};
    r.known = 1; rows.push_back(r);
    // Plain cross: path (0,-1)->(0,1) against wall (1,0)->(-1,0); den > 0 here, so a miss.
    r.pair = {32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000,
              32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000};
    r.known = 0; rows.push_back(r);
    // Same wall with vertices swapped (sign of den flips).
    r.pair = {32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000,
              32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000};
    rows.push_back(r);
    // Path reversed.
    r.pair = {32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000,
              -32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000};
    rows.push_back(r);
    // Z test: wall above the path's Z range -> miss.
    r.pair = {32'sh0004_0000, 32'sh0000_0000, 32'sh0003_0000, 32'sh0000_0000,
              32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000};
    r.known = 1; rows.push_back(r);
    // Parallel segments on one line.
    r.pair = {32'sh0000_0000, 32'sh0002_0000, 32'sh0000_0000, -32'sh0002_0000,
              32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000};
    r.known = 0; rows.push_back(r);
    // Touching at an end point.
    r.pair = {32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0002_0000,
              32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000};
    rows.push_back(r);
    // Wrapped extremes: all max, all min, mixed.
    r.pair = {8{32'sh7FFF_FFFF}}; rows.push_back(r);
    r.pair = {8{32'sh8000_0000}}; rows.push_back(r);
    r.pair = {32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    rows.push_back(r);
    r.pair = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
    rows.push_back(r);
    r.pair = {8{32'hFFFF_FFFF}}; rows.push_back(r);
    r.pair = {8{32'h5555_5555}}; rows.push_back(r);
    r.pair = {8{32'hAAAA_AAAA}}; rows.push_back(r);
    // Large crossing whose products wrap, then one with tiny coordinates.
    r.pair = {32'sh0000_0000, 32'sh4000_0000, 32'sh0000_0000, -32'sh4000_0000,
              32'sh4000_0000, 32'sh0000_0000, -32'sh4000_0000, 32'sh0000_0000};
    rows.push_back(r);
    r.pair = {32'sh0000_8000, -32'sh0000_0001, 32'sh0000_8000, 32'sh0000_0003,
              32'sh0000_0001, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000};
    rows.push_back(r);

    foreach (rows[k]) begin
      c = cross_path(rows[k].pair);
      if (rows[k].known && c !== rows[k].answer) begin
        report_mismatch($sformatf("directed row %0d hit flag", k), 32'(c.hit),
                        32'(rows[k].answer.hit));
      end
      send_pair(rows[k].pair);
    end

    // Random part; one quiet stretch with no idling on either side.
    for (i = 0; i < RANDOM_PAIRS; i++) begin
      quiet_sink = (i >= 700 && i < 850);
      p = rand_pair();
      send_pair(p);
    end
    s_tvalid <= 1'b0;
    quiet_sink = 1'b0;

    // Drain, then let the pipe settle.
    drain = 0;
    while (crossing_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);

    $display("covered %0d words (%0d hits) incl. extremes, parallel and end-touch cases",
             word_count, hit_count);
    if (crossing_q.size() != 0) begin
      report_mismatch("results never arrived", 32'(crossing_q.size()), 32'(0));
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/pwsi_pkg.sv
sv/pwsi_cell.sv
sv/pwsi_front.sv
sv/path_wall_segment_intersect.sv
tb/sv/tb_top.sv
